>>> sv/pfk_pkg.sv
// ----------------------------------------------------------------------------
// pfk_pkg: shared types and constants for the planar chain kinematics core
// Fixed-point formats, CORDIC arctangent table, multiplier sequencer codes.
// ----------------------------------------------------------------------------
package pfk_pkg;

  // Field widths of the channel words
  localparam int ANGLE_IN_BITS = 16;
  localparam int LEN_BITS      = 16;
  localparam int OUT_BITS      = 32;

  // Datapath configuration
  localparam int ANGLE_BITS   = 16;  // used low bits of the angle, 2^ANGLE_BITS = full turn
  localparam int FRAC_BITS    = 16;  // rotation entries Q2.FRAC_BITS
  localparam int CORDIC_STEPS = 16;
  localparam int POS_BITS     = 32;  // accumulated translation width

  // CORDIC datapath
  localparam int CORDIC_FRAC  = 30;
  localparam int ATAN_COUNT   = 24;
  localparam int ATAN_IDX_W   = $clog2(ATAN_COUNT);
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
  localparam int CNT_W        = $clog2(CORDIC_ITERS);
  localparam int CW           = 34;

  // Multiplier datapath
  localparam int ROT_W = FRAC_BITS + 2;
  localparam int VEC_W = LEN_BITS + ROT_W - (FRAC_BITS - 8);
  localparam int A_W   = (LEN_BITS + 1 > ROT_W) ? LEN_BITS + 1 : ROT_W;
  localparam int B_W   = (ROT_W > VEC_W) ? ROT_W : VEC_W;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = P_W + 1;
  localparam int RR_W  = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF_V = ACC_W'((1 << (FRAC_BITS - 8)) >> 1);
  localparam logic signed [ACC_W-1:0] HALF_F = ACC_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } pfk_state_t;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_mode_t;

  typedef enum logic [2:0] {
    DST_VX,
    DST_VY,
    DST_N00,
    DST_N01,
    DST_N10,
    DST_N11,
    DST_TX,
    DST_TY
  } mac_dst_t;

  typedef enum logic [3:0] {
    STEP_VX,
    STEP_VY,
    STEP_N00_A,
    STEP_N00_B,
    STEP_N01_A,
    STEP_N01_B,
    STEP_N10_A,
    STEP_N10_B,
    STEP_N11_A,
    STEP_N11_B,
    STEP_TX_A,
    STEP_TX_B,
    STEP_TY_A,
    STEP_TY_B
  } pfk_step_t;

  typedef struct packed {
    logic      valid;
    logic      last;   // final product of a sum, write back afterwards
    mac_mode_t mode;
    mac_dst_t  dst;
  } mac_op_t;

  typedef struct packed {
    logic     valid;
    mac_dst_t dst;
  } mac_res_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> sv/pfk_link_if.sv
// ----------------------------------------------------------------------------
// pfk_link_if: link input channel
// One word per link: joint angle, link length, last-link flag.
// ----------------------------------------------------------------------------
interface pfk_link_if import pfk_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ANGLE_IN_BITS-1:0] joint_angle;
  logic [LEN_BITS-1:0]      link_length;
  logic                     last_link;

  modport source (output valid, output joint_angle, output link_length, output last_link,
                  input ready);
  modport sink (input valid, input joint_angle, input link_length, input last_link,
                output ready);
endinterface

>>> sv/pfk_pos_if.sv
// ----------------------------------------------------------------------------
// pfk_pos_if: end position output channel
// One word per link: saturated end point and chain-done flag.
// ----------------------------------------------------------------------------
interface pfk_pos_if import pfk_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] end_x;
  logic signed [OUT_BITS-1:0] end_y;
  logic                       chain_done;

  modport source (output valid, output end_x, output end_y, output chain_done,
                  input ready);
  modport sink (input valid, input end_x, input end_y, input chain_done,
                output ready);
endinterface

>>> sv/pfk_cordic.sv
// ----------------------------------------------------------------------------
// pfk_cordic: iterative CORDIC rotator
// One micro-rotation per cycle, then quadrant fix, rounding and saturation.
// ----------------------------------------------------------------------------
module pfk_cordic import pfk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ANGLE_IN_BITS-1:0] angle,
  output logic                     done,
  output logic signed [ROT_W-1:0]  cos_val,
  output logic signed [ROT_W-1:0]  sin_val
);

  localparam int SH = CORDIC_FRAC - FRAC_BITS;
  localparam int RW = CW - SH;
  localparam logic signed [CW-1:0] GAIN = CW'(32'h26DD3B6A);
  localparam logic signed [CW-1:0] HALF = CW'(1) << (SH - 1);
  localparam logic signed [RW-1:0] RMAX = {{(RW-ROT_W+1){1'b0}}, {(ROT_W-1){1'b1}}};
  localparam logic signed [RW-1:0] RMIN = {{(RW-ROT_W+1){1'b1}}, {(ROT_W-1){1'b0}}};

  logic              busy;
  logic              fin;
  logic [CNT_W-1:0]  cnt;
  logic signed [CW-1:0] x, y, z;
  logic [1:0]        quad;

  logic [31:0] turn, qsum, resid;
  logic signed [CW-1:0] xs, ys, at;
  logic signed [CW-1:0] xq, yq, xh, yh;
  logic signed [RW-1:0] xr, yr;

  always_comb begin
    turn  = (32'(angle) & ((32'd1 << ANGLE_BITS) - 32'd1)) << (32 - ANGLE_BITS);
    qsum  = turn + 32'h4000_0000;
    resid = turn - {qsum[31:30], 30'd0};
    xs    = x >>> cnt;
    ys    = y >>> cnt;
    at    = $signed(CW'(atan_turn(ATAN_IDX_W'(cnt))));
  end

  // Quadrant restore is an exact quarter-turn rotation
  always_comb begin
    unique case (quad)
      2'd0: begin
        xq = x;
        yq = y;
      end
      2'd1: begin
        xq = -y;
        yq = x;
      end
      2'd2: begin
        xq = -x;
        yq = -y;
      end
      default: begin
        xq = y;
        yq = -x;
      end
    endcase
    xh = (xq + HALF) >>> SH;
    yh = (yq + HALF) >>> SH;
    xr = xh[RW-1:0];
    yr = yh[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(CORDIC_ITERS - 1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= GAIN;
      y    <= '0;
      z    <= CW'($signed(resid));
      quad <= qsum[31:30];
      cnt  <= '0;
    end else if (busy) begin
      if (!z[CW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      cnt <= cnt + 1'b1;
    end
    if (fin) begin
      if (xr > RMAX)      cos_val <= RMAX[ROT_W-1:0];
      else if (xr < RMIN) cos_val <= RMIN[ROT_W-1:0];
      else                cos_val <= xr[ROT_W-1:0];
      if (yr > RMAX)      sin_val <= RMAX[ROT_W-1:0];
      else if (yr < RMIN) sin_val <= RMIN[ROT_W-1:0];
      else                sin_val <= yr[ROT_W-1:0];
    end
  end

endmodule

>>> sv/pfk_mac.sv
// ----------------------------------------------------------------------------
// pfk_mac: shared multiply-accumulate unit
// Registered product, then load-with-round, add or subtract into the sum.
// ----------------------------------------------------------------------------
module pfk_mac import pfk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_op_t                 op,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  output mac_res_t                res,
  output logic signed [ACC_W-1:0] acc
);

  mac_op_t              stg;
  logic signed [P_W-1:0] prod;
  logic signed [ACC_W-1:0] half;

  // rounding constant goes in with the first product
  assign half = (stg.dst == DST_VX || stg.dst == DST_VY) ? HALF_V : HALF_F;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg <= '0;
      res <= '0;
    end else begin
      stg       <= op;
      res.valid <= stg.valid && stg.last;
      res.dst   <= stg.dst;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (stg.valid) begin
      unique case (stg.mode)
        MAC_LOAD: acc <= ACC_W'(prod) + half;
        MAC_ADD:  acc <= acc + ACC_W'(prod);
        MAC_SUB:  acc <= acc - ACC_W'(prod);
        default:  acc <= acc;
      endcase
    end
  end

endmodule

>>> sv/planar_chain_forward_kinematics_core.sv
// ----------------------------------------------------------------------------
// planar_chain_forward_kinematics_core: planar serial chain end positions
// Accumulates 2x3 rigid transforms link by link and emits each link's end.
// ----------------------------------------------------------------------------
// Usage:
//   link : one word per link (joint_angle, link_length, last_link), taken
//          with valid/ready. ready is high only while the core is idle.
//   pos  : one word per link (end_x, end_y, chain_done), Q24.8 in link_length units, saturated.
//   A link is taken only while the core is idle, so the next link is not
//   accepted until the previous result has gone into the output register.
//   Each link runs through the CORDIC rotator, one micro-rotation a cycle,
//   followed by 14 issues to the single shared multiplier (link vector,
//   four rotation entries, two translation increments), through its product
//   and accumulator registers, and a write-back into the working values.
//   The result sits in an output register, so the next link is accepted
//   while pos waits on ready; a second finished result holds inside the
//   core until the register frees up.
//   Reset (rst, synchronous) sets the accumulator to identity at the origin.
//   After a word with last_link set, the accumulator returns to identity.
// ----------------------------------------------------------------------------
module planar_chain_forward_kinematics_core import pfk_pkg::*; (
  input logic       clk,
  input logic       rst,
  pfk_link_if.sink  link,
  pfk_pos_if.source pos
);

  localparam int SUM_W = ((POS_BITS > RR_W) ? POS_BITS : RR_W) + 1;
  localparam int EXT_W = (POS_BITS > OUT_BITS) ? POS_BITS : OUT_BITS;

  localparam logic signed [RR_W-1:0]  ROT_MAX = {{(RR_W-ROT_W+1){1'b0}}, {(ROT_W-1){1'b1}}};
  localparam logic signed [RR_W-1:0]  ROT_MIN = {{(RR_W-ROT_W+1){1'b1}}, {(ROT_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] POS_MAX =
    {{(SUM_W-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_MIN =
    {{(SUM_W-POS_BITS+1){1'b1}}, {(POS_BITS-1){1'b0}}};
  localparam logic signed [EXT_W-1:0] OUT_MAX =
    {{(EXT_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] OUT_MIN =
    {{(EXT_W-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};
  localparam logic signed [ROT_W-1:0] ROT_ONE = ROT_W'(1) << FRAC_BITS;

  // Sequencer
  pfk_state_t state, state_next;
  pfk_step_t  step;

  // Accumulated transform
  logic signed [ROT_W-1:0]    r00, r01, r10, r11;
  logic signed [POS_BITS-1:0] tx, ty;

  // Per-link working values
  logic [LEN_BITS-1:0]     len_q;
  logic                    last_q;
  logic signed [VEC_W-1:0] vx, vy;
  logic signed [ROT_W-1:0] n00, n01, n10, n11;

  // Output register
  logic                       out_valid;
  logic signed [OUT_BITS-1:0] out_x, out_y;
  logic                       out_done;

  // Units
  logic                    cs_done;
  logic signed [ROT_W-1:0] cos_val, sin_val;
  mac_op_t                 op;
  mac_res_t                res;
  logic signed [A_W-1:0]   mac_a;
  logic signed [B_W-1:0]   mac_b;
  logic signed [ACC_W-1:0] acc;

  logic in_take, out_load;

  pfk_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (in_take),
    .angle   (link.joint_angle),
    .done    (cs_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  pfk_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .a   (mac_a),
    .b   (mac_b),
    .res (res),
    .acc (acc)
  );

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (link.valid) state_next = ST_CORDIC;
      ST_CORDIC: if (cs_done) state_next = ST_MAC;
      ST_MAC:    if (step == STEP_TY_B) state_next = ST_DRAIN;
      ST_DRAIN:  if (res.valid && res.dst == DST_TY) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || pos.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---- outputs of the sequencer ----
  always_comb begin
    in_take  = (state == ST_IDLE) && link.valid;
    out_load = (state == ST_DONE) && (!out_valid || pos.ready);
  end

  // Multiplier program: operands, accumulate mode and write-back target per step
  always_comb begin
    op.valid = (state == ST_MAC);
    mac_a    = A_W'($signed({1'b0, len_q}));
    mac_b    = B_W'(cos_val);
    op.last  = 1'b1;
    op.mode  = MAC_LOAD;
    op.dst   = DST_VX;
    unique case (step)
      STEP_VX: begin
        mac_a = A_W'($signed({1'b0, len_q}));
        mac_b = B_W'(cos_val);
      end
      STEP_VY: begin
        mac_a  = A_W'($signed({1'b0, len_q}));
        mac_b  = B_W'(sin_val);
        op.dst = DST_VY;
      end
      STEP_N00_A: begin
        mac_a = A_W'(r00); mac_b = B_W'(cos_val);
        op.last = 1'b0; op.dst = DST_N00;
      end
      STEP_N00_B: begin
        mac_a = A_W'(r01); mac_b = B_W'(sin_val);
        op.mode = MAC_ADD; op.dst = DST_N00;
      end
      STEP_N01_A: begin
        mac_a = A_W'(r01); mac_b = B_W'(cos_val);
        op.last = 1'b0; op.dst = DST_N01;
      end
      STEP_N01_B: begin
        mac_a = A_W'(r00); mac_b = B_W'(sin_val);
        op.mode = MAC_SUB; op.dst = DST_N01;
      end
      STEP_N10_A: begin
        mac_a = A_W'(r10); mac_b = B_W'(cos_val);
        op.last = 1'b0; op.dst = DST_N10;
      end
      STEP_N10_B: begin
        mac_a = A_W'(r11); mac_b = B_W'(sin_val);
        op.mode = MAC_ADD; op.dst = DST_N10;
      end
      STEP_N11_A: begin
        mac_a = A_W'(r11); mac_b = B_W'(cos_val);
        op.last = 1'b0; op.dst = DST_N11;
      end
      STEP_N11_B: begin
        mac_a = A_W'(r10); mac_b = B_W'(sin_val);
        op.mode = MAC_SUB; op.dst = DST_N11;
      end
      // translation uses the old rotation; new entries commit at the end
      STEP_TX_A: begin
        mac_a = A_W'(r00); mac_b = B_W'(vx);
        op.last = 1'b0; op.dst = DST_TX;
      end
      STEP_TX_B: begin
        mac_a = A_W'(r01); mac_b = B_W'(vy);
        op.mode = MAC_ADD; op.dst = DST_TX;
      end
      STEP_TY_A: begin
        mac_a = A_W'(r10); mac_b = B_W'(vx);
        op.last = 1'b0; op.dst = DST_TY;
      end
      STEP_TY_B: begin
        mac_a = A_W'(r11); mac_b = B_W'(vy);
        op.mode = MAC_ADD; op.dst = DST_TY;
      end
      default: begin
        op.last = 1'b0;
      end
    endcase
  end

  // ---- write-back arithmetic ----
  logic signed [ACC_W-1:0]    acc_f, acc_v;
  logic signed [RR_W-1:0]     rr;
  logic signed [ROT_W-1:0]    rot_val;
  logic signed [POS_BITS-1:0] t_cur, t_val;
  logic signed [SUM_W-1:0]    t_sum;
  logic signed [EXT_W-1:0]    ex, ey;

  always_comb begin
    acc_f = acc >>> FRAC_BITS;
    acc_v = acc >>> (FRAC_BITS - 8);
    rr    = acc_f[RR_W-1:0];
    if (rr > ROT_MAX)      rot_val = ROT_MAX[ROT_W-1:0];
    else if (rr < ROT_MIN) rot_val = ROT_MIN[ROT_W-1:0];
    else                   rot_val = rr[ROT_W-1:0];
    t_cur = (res.dst == DST_TX) ? tx : ty;
    t_sum = SUM_W'(t_cur) + SUM_W'(rr);
    if (t_sum > POS_MAX)      t_val = POS_MAX[POS_BITS-1:0];
    else if (t_sum < POS_MIN) t_val = POS_MIN[POS_BITS-1:0];
    else                      t_val = t_sum[POS_BITS-1:0];
    ex = EXT_W'(tx);
    ey = EXT_W'(ty);
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_VX;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MAC) step <= pfk_step_t'(step + 1'b1);
      else                 step <= STEP_VX;
      if (out_load)       out_valid <= 1'b1;
      else if (pos.ready) out_valid <= 1'b0;
    end
  end

  // ---- accumulated transform ----
  always_ff @(posedge clk) begin
    if (rst) begin
      r00 <= ROT_ONE;
      r01 <= '0;
      r10 <= '0;
      r11 <= ROT_ONE;
      tx  <= '0;
      ty  <= '0;
    end else if (out_load && last_q) begin
      r00 <= ROT_ONE;
      r01 <= '0;
      r10 <= '0;
      r11 <= ROT_ONE;
      tx  <= '0;
      ty  <= '0;
    end else begin
      if (out_load) begin
        r00 <= n00;
        r01 <= n01;
        r10 <= n10;
        r11 <= n11;
      end
      if (res.valid && res.dst == DST_TX) tx <= t_val;
      if (res.valid && res.dst == DST_TY) ty <= t_val;
    end
  end

  // ---- working values and output word ----
  always_ff @(posedge clk) begin
    if (in_take) begin
      len_q  <= link.link_length;
      last_q <= link.last_link;
    end
    if (res.valid) begin
      unique case (res.dst)
        DST_VX:  vx  <= acc_v[VEC_W-1:0];
        DST_VY:  vy  <= acc_v[VEC_W-1:0];
        DST_N00: n00 <= rot_val;
        DST_N01: n01 <= rot_val;
        DST_N10: n10 <= rot_val;
        DST_N11: n11 <= rot_val;
        default: ;
      endcase
    end
    if (out_load) begin
      if (ex > OUT_MAX)      out_x <= OUT_MAX[OUT_BITS-1:0];
      else if (ex < OUT_MIN) out_x <= OUT_MIN[OUT_BITS-1:0];
      else                   out_x <= ex[OUT_BITS-1:0];
      if (ey > OUT_MAX)      out_y <= OUT_MAX[OUT_BITS-1:0];
      else if (ey < OUT_MIN) out_y <= OUT_MIN[OUT_BITS-1:0];
      else                   out_y <= ey[OUT_BITS-1:0];
      out_done <= last_q;
    end
  end

  assign link.ready     = (state == ST_IDLE);
  assign pos.valid      = out_valid;
  assign pos.end_x      = out_x;
  assign pos.end_y      = out_y;
  assign pos.chain_done = out_done;

endmodule

>>> dv/tb_planar_chain_forward_kinematics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_chain_forward_kinematics_core: self-checking bench for the core
// Feeds link words in bursts, stalls the position side on shifting patterns,
// and compares every end-point word with a bit-true transform model.
// ----------------------------------------------------------------------------
module tb_planar_chain_forward_kinematics_core import pfk_pkg::*; ();

  localparam int N_ITEMS    = 1100;
  localparam int IDLE_LIMIT = 2000;              // cycles with no handshake at all
  localparam int TAIL_WAIT  = CORDIC_STEPS + 40; // a bit past one link latency

  // One expected position word
  typedef struct {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic                       done;
  } end_point_t;

  // --------------------------------------------------------------------------
  // Pose tracker: keeps the accumulated 2x3 transform, predicts each link's
  // end point and checks the words that come out of the core.
  // --------------------------------------------------------------------------
  class chain_pose_board;
    longint     r00, r01, r10, r11, tx, ty;
    longint     atan_tbl[24];
    end_point_t end_points_due[$];
    int         errors;

    function new();
      atan_tbl = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      errors = 0;
      home();
    endfunction

    function void home();
      r00 = longint'(1) << FRAC_BITS;
      r11 = longint'(1) << FRAC_BITS;
      r01 = 0;
      r10 = 0;
      tx  = 0;
      ty  = 0;
    endfunction

    // add half the divisor, then floor
    function longint round_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // CORDIC cosine/sine of a turn fraction, rounded to Q2.FRAC_BITS
    function void unit_vector(bit [ANGLE_IN_BITS-1:0] angle, output longint c,
                              output longint s);
      bit [31:0] turn, q, resid;
      longint    z, x, y, nx;
      turn  = 32'((longint'(angle) & ((longint'(1) << ANGLE_BITS) - 1)) << (32 - ANGLE_BITS));
      q     = (turn + 32'h4000_0000) >> 30;
      resid = turn - (q << 30);
      z     = longint'($signed(resid));
      x     = 64'h26DD3B6A;
      y     = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - atan_tbl[i];
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + atan_tbl[i];
        end
        x = nx;
      end
      // put the quadrant back with an exact quarter-turn rotation
      unique case (q[1:0])
        2'd0: ;
        2'd1: begin nx = -y; y = x; x = nx; end
        2'd2: begin x = -x; y = -y; end
        default: begin nx = y; y = -x; x = nx; end
      endcase
      c = clip(round_shift(x, CORDIC_FRAC - FRAC_BITS), FRAC_BITS + 2);
      s = clip(round_shift(y, CORDIC_FRAC - FRAC_BITS), FRAC_BITS + 2);
    endfunction

    // accepted link word: advance the pose, queue the end point
    function void add_link(bit [ANGLE_IN_BITS-1:0] angle, bit [LEN_BITS-1:0] len, bit last);
      longint     c, s, vx, vy, n00, n01, n10, n11;
      end_point_t ep;
      unit_vector(angle, c, s);
      vx = round_shift(longint'(len) * c, FRAC_BITS - 8);
      vy = round_shift(longint'(len) * s, FRAC_BITS - 8);
      // translation uses the old rotation
      tx = clip(tx + round_shift(r00 * vx + r01 * vy, FRAC_BITS), POS_BITS);
      ty = clip(ty + round_shift(r10 * vx + r11 * vy, FRAC_BITS), POS_BITS);
      n00 = clip(round_shift(r00 * c + r01 * s, FRAC_BITS), FRAC_BITS + 2);
      n01 = clip(round_shift(r01 * c - r00 * s, FRAC_BITS), FRAC_BITS + 2);
      n10 = clip(round_shift(r10 * c + r11 * s, FRAC_BITS), FRAC_BITS + 2);
      n11 = clip(round_shift(r11 * c - r10 * s, FRAC_BITS), FRAC_BITS + 2);
      r00 = n00;
      r01 = n01;
      r10 = n10;
      r11 = n11;
      ep.x    = OUT_BITS'(clip(tx, OUT_BITS));
      ep.y    = OUT_BITS'(clip(ty, OUT_BITS));
      ep.done = last;
      end_points_due = {end_points_due, ep};
      if (last) home();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_pos(logic signed [OUT_BITS-1:0] x, logic signed [OUT_BITS-1:0] y, logic done);
      end_point_t ep;
      if (end_points_due.size() == 0) begin
        report_mismatch($sformatf("unexpected position word x=%0d y=%0d", x, y));
        return;
      end
      ep = end_points_due.pop_front();
      if (x !== ep.x)
        report_mismatch($sformatf("end_x got %0d want %0d", x, ep.x));
      if (y !== ep.y)
        report_mismatch($sformatf("end_y got %0d want %0d", y, ep.y));
      if (done !== ep.done)
        report_mismatch($sformatf("chain_done got %b want %b", done, ep.done));
    endtask

    function int pending();
      return end_points_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  pfk_link_if link ();
  pfk_pos_if  pos ();

  planar_chain_forward_kinematics_core uut (
    .clk  (clk),
    .rst  (rst),
    .link (link.sink),
    .pos  (pos.source)
  );

  chain_pose_board board = new();

  int n_sent      = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Send one link word and hold it until the core takes it. After the
  // handshake either stay valid for the next word of the burst or drop valid
  // and idle for a random gap; idle payload is junk on purpose.
  // --------------------------------------------------------------------------
  task automatic send_link(bit [ANGLE_IN_BITS-1:0] angle, bit [LEN_BITS-1:0] len, bit last);
    link.valid       <= 1'b1;
    link.joint_angle <= angle;
    link.link_length <= len;
    link.last_link   <= last;
    @(posedge clk);
    while (!link.ready) @(posedge clk);
    board.add_link(angle, len, last);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      link.valid       <= 1'b0;
      link.joint_angle <= ANGLE_IN_BITS'($urandom);
      link.link_length <= LEN_BITS'($urandom);
      link.last_link   <= 1'($urandom);
      // short gaps land inside the link work, long ones past it
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(1, 60)) @(posedge clk);
      // mostly short bursts, now and then a long stretch with no idling
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(0, 8);
    end
  endtask

  // angles: mostly anything, some right on the octant and quadrant edges
  function automatic bit [ANGLE_IN_BITS-1:0] pick_angle();
    bit [ANGLE_IN_BITS-1:0] edges [8] = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000,
                                          16'h8000, 16'hC000, 16'hE000, 16'hFFFF};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 7)];
    return ANGLE_IN_BITS'($urandom);
  endfunction

  function automatic bit [LEN_BITS-1:0] pick_length();
    unique case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return LEN_BITS'($urandom_range(0, 16'h0400));
      default: return LEN_BITS'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: ready follows a pattern that changes every phase - always
  // ready, a random 16-bit mask, one cycle in sixteen, or coin flips.
  // --------------------------------------------------------------------------
  initial begin
    int          phase_left;
    int          mode;
    int          idx;
    bit [15:0]   mask;
    phase_left = 0;
    mode       = 0;
    idx        = 0;
    mask       = '1;
    pos.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 200);
        mode       = $urandom_range(0, 9);
        mask       = 16'($urandom) | 16'h0001;
      end
      phase_left--;
      idx++;
      if (mode < 3)       pos.ready <= 1'b1;
      else if (mode < 6)  pos.ready <= mask[idx % 16];
      else if (mode < 8)  pos.ready <= ((idx % 16) == 0);
      else                pos.ready <= 1'($urandom);
    end
  end

  // check every accepted position word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && pos.valid && pos.ready)
      board.check_pos(pos.end_x, pos.end_y, pos.chain_done);
  end

  // watchdog: count cycles with no handshake on either side
  always @(posedge clk) begin
    if ((link.valid && link.ready) || (pos.valid && pos.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb_planar_chain_forward_kinematics_core: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main stimulus
  // --------------------------------------------------------------------------
  initial begin
    int                     chain_no;
    int                     chain_len;
    bit [ANGLE_IN_BITS-1:0] a;
    rst              <= 1'b1;
    link.valid       <= 1'b0;
    link.joint_angle <= '0;
    link.link_length <= '0;
    link.last_link   <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single-link chains at the field extremes
    send_link(16'h0000, 16'h0000, 1'b1);   // zero length
    send_link(16'h0000, 16'hFFFF, 1'b1);   // longest link
    send_link(16'hFFFF, 16'hFFFF, 1'b1);   // all ones

    // one chain walking the octant and quadrant boundaries
    send_link(16'h2000, 16'h0100, 1'b0);
    send_link(16'h4000, 16'h0280, 1'b0);
    send_link(16'h6000, 16'h1234, 1'b0);
    send_link(16'h8000, 16'hFFFF, 1'b0);
    send_link(16'hA000, 16'h0001, 1'b0);
    send_link(16'hC000, 16'h8000, 1'b0);
    send_link(16'hE000, 16'h7FFF, 1'b0);
    send_link(16'h1FFF, 16'h5555, 1'b0);
    send_link(16'hDFFF, 16'hAAAA, 1'b0);
    send_link(16'h0001, 16'h00FF, 1'b1);

    // square: four quarter turns should land near the origin
    send_link(16'h4000, 16'h8000, 1'b0);
    send_link(16'h4000, 16'h8000, 1'b0);
    send_link(16'h4000, 16'h8000, 1'b0);
    send_link(16'h4000, 16'h8000, 1'b1);

    // half turn then a tiny step
    send_link(16'h8000, 16'hFFFF, 1'b0);
    send_link(16'h0000, 16'h0001, 1'b1);

    // Random chains. A few are long reaches of full-length, nearly straight
    // links that drive the position into saturation and then drift on.
    chain_no = 0;
    while (n_sent < N_ITEMS) begin
      chain_no++;
      if (chain_no == 3 || chain_no == 60 || $urandom_range(0, 79) == 0) begin
        chain_len = $urandom_range(130, 160);
        for (int k = 0; k < chain_len; k++) begin
          if (k == 0) a = ANGLE_IN_BITS'($urandom);
          else if (k == chain_len / 2 && $urandom_range(0, 1) == 1) a = 16'h8000; // turn back
          else a = ANGLE_IN_BITS'($urandom_range(0, 256) - 128);
          send_link(a, LEN_BITS'($urandom_range(16'hF000, 16'hFFFF)), k == chain_len - 1);
        end
      end else begin
        chain_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 10);
        for (int k = 0; k < chain_len; k++)
          send_link(pick_angle(), pick_length(), k == chain_len - 1);
      end
    end

    link.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_planar_chain_forward_kinematics_core: PASS");
    end else begin
      $display("tb_planar_chain_forward_kinematics_core: FAIL");
    end
    $finish;
  end

endmodule
